/* sv/hbcd_pkg.sv */
// Types, constants and codes of the hashed buffer cache directory.
// Used by hbcd_store, hbcd_seq and hashed_buffer_cache_directory.
package hbcd_pkg;

   localparam int NUM_SETS = 64;
   localparam int WAYS     = 8;
   localparam int SET_W    = $clog2(NUM_SETS);
   localparam int WAY_W    = $clog2(WAYS);
   localparam int ENT_W    = SET_W + WAY_W;
   localparam int NUM_ENT  = NUM_SETS * WAYS;
   localparam int HASH_MUL = 1009;

   localparam logic [2:0] OP_GET   = 3'd0;
   localparam logic [2:0] OP_MARK  = 3'd1;
   localparam logic [2:0] OP_CLEAR = 3'd2;
   localparam logic [2:0] OP_INVAL = 3'd3;
   localparam logic [2:0] OP_REL   = 3'd4;
   localparam logic [2:0] OP_SCAN  = 3'd5;

   localparam logic [3:0] ST_HIT       = 4'd0;
   localparam logic [3:0] ST_FILL_READ = 4'd1;
   localparam logic [3:0] ST_FILL_INIT = 4'd2;
   localparam logic [3:0] ST_PROBE     = 4'd3;
   localparam logic [3:0] ST_VICTIM    = 4'd4;
   localparam logic [3:0] ST_ALL_RES   = 4'd5;
   localparam logic [3:0] ST_DONE      = 4'd6;
   localparam logic [3:0] ST_WRITE_DUE = 4'd7;
   localparam logic [3:0] ST_NONE      = 4'd8;

   localparam int MK_READ  = 0;
   localparam int MK_PROBE = 1;
   localparam int MK_RES   = 2;
   localparam int MK_IMM   = 3;
   localparam int MK_DIRTY = 4;

   typedef struct packed {
      logic [7:0]  dev;
      logic [31:0] addr;
      logic        valid;
      logic [4:0]  marks;
   } entry_type;

   typedef struct packed {
      logic [ENT_W-1:0] rd_idx;
      logic [SET_W-1:0] head_rd_set;
      logic             data_we;
      logic [ENT_W-1:0] data_idx;
      entry_type        data_val;
      logic             next_we;
      logic [ENT_W-1:0] next_idx;
      logic [WAY_W-1:0] next_val;
      logic             prev_we;
      logic [ENT_W-1:0] prev_idx;
      logic [WAY_W-1:0] prev_val;
      logic             head_we;
      logic [SET_W-1:0] head_set;
      logic [WAY_W-1:0] head_val;
   } mem_ctl_type;

   typedef struct packed {
      entry_type        data;
      logic [WAY_W-1:0] next;
      logic [WAY_W-1:0] prev;
      logic [WAY_W-1:0] head;
   } mem_rd_type;

   typedef struct packed {
      logic [3:0]       status;
      logic [SET_W-1:0] set;
      logic [WAY_W-1:0] way;
      logic [7:0]       dev;
      logic [31:0]      addr;
      logic             more;
   } rsp_type;

endpackage

/* sv/hbcd_store.sv */
// Directory storage: entry words, recency links and set heads.
// Depends on hbcd_pkg for the control and read word types.
module hbcd_store (
   input  logic                  clock,
   input  hbcd_pkg::mem_ctl_type ctl,
   output hbcd_pkg::mem_rd_type  rd
);

   hbcd_pkg::entry_type            data_mem [hbcd_pkg::NUM_ENT];
   logic [hbcd_pkg::WAY_W-1:0]     next_mem [hbcd_pkg::NUM_ENT];
   logic [hbcd_pkg::WAY_W-1:0]     prev_mem [hbcd_pkg::NUM_ENT];
   logic [hbcd_pkg::WAY_W-1:0]     head_mem [hbcd_pkg::NUM_SETS];
   hbcd_pkg::mem_rd_type           rd_ff;

   always_ff @(posedge clock) begin
      if (ctl.data_we) begin
         data_mem[ctl.data_idx] <= ctl.data_val;
      end
      if (ctl.next_we) begin
         next_mem[ctl.next_idx] <= ctl.next_val;
      end
      if (ctl.prev_we) begin
         prev_mem[ctl.prev_idx] <= ctl.prev_val;
      end
      if (ctl.head_we) begin
         head_mem[ctl.head_set] <= ctl.head_val;
      end
      rd_ff.data <= data_mem[ctl.rd_idx];
      rd_ff.next <= next_mem[ctl.rd_idx];
      rd_ff.prev <= prev_mem[ctl.rd_idx];
      rd_ff.head <= head_mem[ctl.head_rd_set];
   end

   assign rd = rd_ff;

endmodule

/* sv/hbcd_seq.sv */
// Sequencer of the directory: clearing pass, set walks, relinking, results.
// Depends on hbcd_pkg; drives hbcd_store through one control word.
module hbcd_seq (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [2:0]                      opcode,
   input  logic [7:0]                      dev_num,
   input  logic [31:0]                     block_addr,
   input  logic [3:0]                      flags,
   input  logic [hbcd_pkg::SET_W-1:0]      set_sel,
   input  logic [hbcd_pkg::WAY_W-1:0]      way_sel,
   output hbcd_pkg::mem_ctl_type           ctl,
   input  hbcd_pkg::mem_rd_type            rd,
   output logic                            rsp_valid,
   output hbcd_pkg::rsp_type               rsp
);

   typedef enum logic [3:0] {
      S_CLR, S_IDLE, S_HEAD, S_HEAD2, S_WALK_RD, S_WALK_CHK, S_REL1, S_REL2,
      S_REL3, S_VIC_RD, S_VIC_CHK, S_SCAN_RD, S_SCAN_CHK, S_ENT_RD, S_ENT_DO
   } state_type;

   localparam int SW = hbcd_pkg::SET_W;
   localparam int WW = hbcd_pkg::WAY_W;
   localparam int EW = hbcd_pkg::ENT_W;
   localparam logic [WW-1:0] LAST_STEP = WW'(hbcd_pkg::WAYS - 1);

   state_type state_ff, state_in;
   logic [2:0]  op_ff, op_in;
   logic [7:0]  dev_ff, dev_in;
   logic [31:0] addr_ff, addr_in;
   logic [3:0]  flags_ff, flags_in;
   logic [SW-1:0] set_ff, set_in;
   logic [WW-1:0] s_ff, s_in, p_ff, p_in, sp0_ff, sp0_in, pn_ff, pn_in, pp_ff, pp_in;
   logic [WW-1:0] cnt_ff, cnt_in, last_ff, last_in;
   logic [1:0]  found_ff, found_in;
   logic [7:0]  ldev_ff, ldev_in;
   logic [31:0] laddr_ff, laddr_in;
   hbcd_pkg::entry_type ent_ff, ent_in;
   logic [EW-1:0] clr_ff, clr_in;
   logic rsp_valid_ff, rsp_valid_in;
   hbcd_pkg::rsp_type rsp_ff, rsp_in;

   logic [17:0]   hash_prod;
   logic [SW-1:0] hash_set;
   logic [WW-1:0] vp, sp;
   hbcd_pkg::entry_type q;
   logic hit;

   assign hash_prod = 18'(dev_num) * 18'(hbcd_pkg::HASH_MUL);
   assign hash_set  = block_addr[SW-1:0] + hash_prod[SW-1:0];
   assign q   = rd.data;
   assign hit = q.valid && (q.dev == dev_ff) && (q.addr == addr_ff);
   assign vp  = (cnt_ff == '0) ? rd.prev : sp0_ff;
   assign sp  = (pn_ff == s_ff) ? pp_ff : sp0_ff;

   always_comb begin
      state_in = state_ff; op_in = op_ff; dev_in = dev_ff; addr_in = addr_ff;
      flags_in = flags_ff; set_in = set_ff; s_in = s_ff; p_in = p_ff;
      sp0_in = sp0_ff; pn_in = pn_ff; pp_in = pp_ff; cnt_in = cnt_ff;
      last_in = last_ff; found_in = found_ff; ldev_in = ldev_ff;
      laddr_in = laddr_ff; ent_in = ent_ff; clr_in = clr_ff;
      rsp_valid_in = 1'b0; rsp_in = rsp_ff;
      ctl = '0;
      ctl.rd_idx = {set_ff, p_ff};
      ctl.head_rd_set = set_ff;
      case (state_ff)
         S_CLR: begin
            ctl.data_we  = 1'b1;
            ctl.data_idx = clr_ff;
            ctl.next_we  = 1'b1;
            ctl.next_idx = clr_ff;
            ctl.next_val = clr_ff[WW-1:0] + WW'(1);
            ctl.prev_we  = 1'b1;
            ctl.prev_idx = clr_ff;
            ctl.prev_val = clr_ff[WW-1:0] - WW'(1);
            ctl.head_we  = 1'b1;
            ctl.head_set = clr_ff[EW-1:WW];
            clr_in = clr_ff + EW'(1);
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               op_in = opcode; dev_in = dev_num; addr_in = block_addr;
               flags_in = flags; p_in = way_sel; cnt_in = '0;
               found_in = '0; last_in = '0;
               case (opcode)
                  hbcd_pkg::OP_GET: begin
                     set_in = hash_set;
                     state_in = S_HEAD;
                  end
                  hbcd_pkg::OP_SCAN: begin
                     set_in = set_sel;
                     state_in = S_HEAD;
                  end
                  hbcd_pkg::OP_MARK, hbcd_pkg::OP_CLEAR, hbcd_pkg::OP_INVAL,
                  hbcd_pkg::OP_REL: begin
                     set_in = set_sel;
                     state_in = S_ENT_RD;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_in = '{hbcd_pkg::ST_DONE, '0, '0, '0, '0, 1'b0};
                  end
               endcase
            end
         end
         S_HEAD: begin
            state_in = S_HEAD2;
         end
         S_HEAD2: begin
            s_in = rd.head;
            p_in = rd.head;
            state_in = (op_ff == hbcd_pkg::OP_SCAN) ? S_SCAN_RD : S_WALK_RD;
         end
         S_WALK_RD: begin
            state_in = S_WALK_CHK;
         end
         S_WALK_CHK: begin
            if (cnt_ff == '0) begin
               sp0_in = rd.prev;
            end
            if (hit) begin
               ent_in = q;
               ent_in.marks = q.marks | {1'b0, flags_ff};
               if (p_ff == s_ff) begin
                  ctl.data_we  = 1'b1;
                  ctl.data_idx = {set_ff, p_ff};
                  ctl.data_val = ent_in;
                  rsp_valid_in = 1'b1;
                  rsp_in = '{hbcd_pkg::ST_HIT, set_ff, p_ff, q.dev, q.addr, 1'b0};
                  state_in = S_IDLE;
               end else begin
                  pn_in = rd.next;
                  pp_in = rd.prev;
                  state_in = S_REL1;
               end
            end else if ((rd.next == s_ff) || (cnt_ff == LAST_STEP)) begin
               if (flags_ff[hbcd_pkg::MK_PROBE]) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{hbcd_pkg::ST_PROBE, set_ff, '0, '0, '0, 1'b0};
                  state_in = S_IDLE;
               end else begin
                  p_in = vp;
                  cnt_in = '0;
                  state_in = S_VIC_RD;
               end
            end else begin
               p_in = rd.next;
               cnt_in = cnt_ff + WW'(1);
               state_in = S_WALK_RD;
            end
         end
         S_REL1: begin
            ctl.next_we  = 1'b1;
            ctl.next_idx = {set_ff, pp_ff};
            ctl.next_val = pn_ff;
            ctl.prev_we  = 1'b1;
            ctl.prev_idx = {set_ff, pn_ff};
            ctl.prev_val = pp_ff;
            state_in = S_REL2;
         end
         S_REL2: begin
            ctl.next_we  = 1'b1;
            ctl.next_idx = {set_ff, p_ff};
            ctl.next_val = s_ff;
            ctl.prev_we  = 1'b1;
            ctl.prev_idx = {set_ff, p_ff};
            ctl.prev_val = sp;
            state_in = S_REL3;
         end
         S_REL3: begin
            ctl.next_we  = 1'b1;
            ctl.next_idx = {set_ff, sp};
            ctl.next_val = p_ff;
            ctl.prev_we  = 1'b1;
            ctl.prev_idx = {set_ff, s_ff};
            ctl.prev_val = p_ff;
            ctl.head_we  = 1'b1;
            ctl.head_set = set_ff;
            ctl.head_val = p_ff;
            ctl.data_we  = 1'b1;
            ctl.data_idx = {set_ff, p_ff};
            ctl.data_val = ent_ff;
            rsp_valid_in = 1'b1;
            rsp_in = '{hbcd_pkg::ST_HIT, set_ff, p_ff, ent_ff.dev, ent_ff.addr, 1'b0};
            state_in = S_IDLE;
         end
         S_VIC_RD: begin
            state_in = S_VIC_CHK;
         end
         S_VIC_CHK: begin
            if (q.marks[hbcd_pkg::MK_RES]) begin
               if ((p_ff == s_ff) || (cnt_ff == LAST_STEP)) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{hbcd_pkg::ST_ALL_RES, set_ff, '0, '0, '0, 1'b0};
                  state_in = S_IDLE;
               end else begin
                  p_in = rd.prev;
                  cnt_in = cnt_ff + WW'(1);
                  state_in = S_VIC_RD;
               end
            end else if (q.marks[hbcd_pkg::MK_DIRTY]) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{hbcd_pkg::ST_VICTIM, set_ff, p_ff, q.dev, q.addr, 1'b0};
               state_in = S_IDLE;
            end else begin
               ctl.head_we  = 1'b1;
               ctl.head_set = set_ff;
               ctl.head_val = p_ff;
               ctl.data_we  = 1'b1;
               ctl.data_idx = {set_ff, p_ff};
               ctl.data_val = '{dev_ff, addr_ff, 1'b1, {1'b0, flags_ff}};
               rsp_valid_in = 1'b1;
               rsp_in = '{(flags_ff[hbcd_pkg::MK_READ] ? hbcd_pkg::ST_FILL_READ
                                                       : hbcd_pkg::ST_FILL_INIT),
                          set_ff, p_ff, dev_ff, addr_ff, 1'b0};
               state_in = S_IDLE;
            end
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            logic [1:0] f;
            logic [WW-1:0] l;
            logic [7:0] d;
            logic [31:0] a;
            f = found_ff; l = last_ff; d = ldev_ff; a = laddr_ff;
            if (q.marks[hbcd_pkg::MK_DIRTY]) begin
               f = (found_ff == 2'd2) ? 2'd2 : found_ff + 2'd1;
               l = p_ff; d = q.dev; a = q.addr;
            end
            found_in = f; last_in = l; ldev_in = d; laddr_in = a;
            if ((rd.next == s_ff) || (cnt_ff == LAST_STEP)) begin
               rsp_valid_in = 1'b1;
               if (f == 2'd0) begin
                  rsp_in = '{hbcd_pkg::ST_NONE, set_ff, '0, '0, '0, 1'b0};
               end else begin
                  rsp_in = '{hbcd_pkg::ST_WRITE_DUE, set_ff, l, d, a, (f == 2'd2)};
               end
               state_in = S_IDLE;
            end else begin
               p_in = rd.next;
               cnt_in = cnt_ff + WW'(1);
               state_in = S_SCAN_RD;
            end
         end
         S_ENT_RD: begin
            state_in = S_ENT_DO;
         end
         S_ENT_DO: begin
            rsp_valid_in = 1'b1;
            rsp_in = '{hbcd_pkg::ST_DONE, set_ff, p_ff, q.dev, q.addr, 1'b0};
            ctl.data_idx = {set_ff, p_ff};
            ctl.data_val = q;
            case (op_ff)
               hbcd_pkg::OP_MARK: begin
                  ctl.data_we = 1'b1;
                  ctl.data_val.marks[hbcd_pkg::MK_DIRTY] = 1'b1;
               end
               hbcd_pkg::OP_CLEAR: begin
                  ctl.data_we = 1'b1;
                  ctl.data_val.marks[hbcd_pkg::MK_DIRTY] = 1'b0;
                  ctl.data_val.marks[hbcd_pkg::MK_IMM] = 1'b0;
               end
               hbcd_pkg::OP_INVAL: begin
                  ctl.data_we = 1'b1;
                  ctl.data_val = '0;
               end
               default: begin
                  if (q.marks[hbcd_pkg::MK_IMM]) begin
                     rsp_in.status = hbcd_pkg::ST_WRITE_DUE;
                  end
               end
            endcase
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff <= op_in; dev_ff <= dev_in; addr_ff <= addr_in; flags_ff <= flags_in;
      set_ff <= set_in; s_ff <= s_in; p_ff <= p_in; sp0_ff <= sp0_in;
      pn_ff <= pn_in; pp_ff <= pp_in; cnt_ff <= cnt_in; last_ff <= last_in;
      found_ff <= found_in; ldev_ff <= ldev_in; laddr_ff <= laddr_in;
      ent_ff <= ent_in; rsp_ff <= rsp_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

endmodule

/* sv/hashed_buffer_cache_directory.sv */
// Hashed buffer cache directory: one word per command, result strobed once.
// A get holds busy while it reads the set head and walks entries (up to 8 in lookup, up to 8
// in victim search), and while it relinks a hit away from the head in S_REL1 to S_REL3.
// Entry commands and scans hold busy too, unused opcodes not at all; the result is
// strobed in the first cycle with busy low. A new command is taken only while busy is low.
// After reset a clearing pass over all 512 entries runs with busy high; results cannot stall.
module hashed_buffer_cache_directory (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [2:0]                 req_opcode,
   input  logic [7:0]                 req_dev_num,
   input  logic [31:0]                req_block_addr,
   input  logic [3:0]                 req_req_flags,
   input  logic [5:0]                 req_set_sel,
   input  logic [2:0]                 req_way_sel,
   output logic                       rsp_valid,
   output logic [3:0]                 rsp_status,
   output logic [5:0]                 rsp_set_out,
   output logic [2:0]                 rsp_way_out,
   output logic [7:0]                 rsp_entry_dev,
   output logic [31:0]                rsp_entry_addr,
   output logic                       rsp_more_dirty
);

   hbcd_pkg::mem_ctl_type ctl;
   hbcd_pkg::mem_rd_type  rd;
   hbcd_pkg::rsp_type     rsp;

   hbcd_store u_store (
      .clock (clock),
      .ctl   (ctl),
      .rd    (rd)
   );

   hbcd_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .opcode     (req_opcode),
      .dev_num    (req_dev_num),
      .block_addr (req_block_addr),
      .flags      (req_req_flags),
      .set_sel    (req_set_sel),
      .way_sel    (req_way_sel),
      .ctl        (ctl),
      .rd         (rd),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp)
   );

   assign rsp_status     = rsp.status;
   assign rsp_set_out    = rsp.set;
   assign rsp_way_out    = rsp.way;
   assign rsp_entry_dev  = rsp.dev;
   assign rsp_entry_addr = rsp.addr;
   assign rsp_more_dirty = rsp.more;

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_opcode <= hbcd_pkg::OP_SCAN)) |=> busy)
      else $error("command not taken");
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy || start)) else $error("result without command");

endmodule
